// ----- hw/rtl/lpg_pkg.sv -----
// ----------------------------------------------------------------------------
// lpg_pkg
// Shared codes, widths and types of the line pixel generator.
// ----------------------------------------------------------------------------
package lpg_pkg;

   // Command codes carried in req_tuser
   localparam logic CMD_START = 1'b0;
   localparam logic CMD_STEP  = 1'b1;

   // Per-axis step direction, two's complement -1, 0, +1
   typedef enum logic [1:0] {
      DIR_NONE = 2'b00,
      DIR_INC  = 2'b01,
      DIR_DEC  = 2'b11
   } dir_type;

   localparam int COLOR_BITS      = 16;
   localparam int ROW_OFFSET_BITS = 10;
   localparam logic [ROW_OFFSET_BITS-1:0] ROW_OFFSET_RESET = 10'd20;

   // Register file: one register, word addressed
   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_ADDR_BITS = 3;
   localparam logic [0:0] REG_ROW_OFFSET = 1'b0;

endpackage

// ----- hw/rtl/lpg_csr.sv -----
// ----------------------------------------------------------------------------
// lpg_csr
// APB-style register port holding the row offset.
// ----------------------------------------------------------------------------
module lpg_csr import lpg_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0]   csr_paddr,
   input  logic [CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic [CSR_DATA_BITS-1:0]   csr_prdata,
   output logic                       csr_pready,
   output logic [ROW_OFFSET_BITS-1:0] row_offset
);

   logic [ROW_OFFSET_BITS-1:0] row_offset_ff;
   logic [ROW_OFFSET_BITS-1:0] row_offset_in;
   logic [0:0]                 reg_index;
   logic                       write_hit;

   assign csr_pready = 1'b1;
   assign reg_index  = csr_paddr[CSR_ADDR_BITS-1:2];
   assign write_hit  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      row_offset_in = row_offset_ff;
      if (write_hit && (reg_index == REG_ROW_OFFSET)) begin
         row_offset_in = csr_pwdata[ROW_OFFSET_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_offset_ff <= ROW_OFFSET_RESET;
      end else begin
         row_offset_ff <= row_offset_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (reg_index == REG_ROW_OFFSET) begin
         csr_prdata = CSR_DATA_BITS'(row_offset_ff);
      end
   end

   assign row_offset = row_offset_ff;

endmodule

// ----- hw/rtl/lpg_core.sv -----
// ----------------------------------------------------------------------------
// lpg_core
// Line state and one-pixel-per-beat error-accumulator step.
// ----------------------------------------------------------------------------
module lpg_core import lpg_pkg::*; #(
   parameter int COORD_BITS = 10
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic                       req_command,
   input  logic [COORD_BITS-1:0]      req_x_start,
   input  logic [COORD_BITS-1:0]      req_y_start,
   input  logic [COORD_BITS-1:0]      req_x_end,
   input  logic [COORD_BITS-1:0]      req_y_end,
   input  logic [COLOR_BITS-1:0]      req_color,
   input  logic [ROW_OFFSET_BITS-1:0] row_offset,
   output logic                       res_valid,
   input  logic                       res_ready,
   output logic [COORD_BITS-1:0]      res_pixel_x,
   output logic [COORD_BITS:0]        res_pixel_y,
   output logic [COLOR_BITS-1:0]      res_pixel_color,
   output logic                       res_last
);

   localparam int SUM_BITS = ((COORD_BITS > ROW_OFFSET_BITS) ? COORD_BITS : ROW_OFFSET_BITS) + 1;

   logic [COORD_BITS-1:0] cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic [COORD_BITS:0]   err_x_ff, err_x_in, err_y_ff, err_y_in;
   logic [COORD_BITS-1:0] abs_dx_ff, abs_dx_in, abs_dy_ff, abs_dy_in;
   logic [COORD_BITS-1:0] span_ff, span_in;
   dir_type               dir_x_ff, dir_x_in, dir_y_ff, dir_y_in;
   logic [COORD_BITS:0]   pixels_left_ff, pixels_left_in;
   logic [COLOR_BITS-1:0] line_color_ff, line_color_in;
   logic                  busy_ff, busy_in;

   logic                  accept;
   logic [COORD_BITS-1:0] mag_x, mag_y, span_new;
   dir_type               dir_new_x, dir_new_y;
   logic [COORD_BITS:0]   sum_x, sum_y, span_wide;
   logic [SUM_BITS-1:0]   row_sum;

   function automatic logic [COORD_BITS-1:0] axis_mag(input logic [COORD_BITS-1:0] a,
                                                      input logic [COORD_BITS-1:0] b);
      logic [COORD_BITS-1:0] m;
      m = (b > a) ? (b - a) : (a - b);
      return m;
   endfunction

   function automatic dir_type axis_dir(input logic [COORD_BITS-1:0] a,
                                        input logic [COORD_BITS-1:0] b);
      dir_type d;
      if (b > a) begin
         d = DIR_INC;
      end else if (b == a) begin
         d = DIR_NONE;
      end else begin
         d = DIR_DEC;
      end
      return d;
   endfunction

   function automatic logic [COORD_BITS-1:0] axis_move(input logic [COORD_BITS-1:0] c,
                                                       input dir_type d);
      logic [COORD_BITS-1:0] r;
      case (d)
         DIR_INC: r = c + COORD_BITS'(1);
         DIR_DEC: r = c - COORD_BITS'(1);
         default: r = c;
      endcase
      return r;
   endfunction

   assign req_ready = res_ready;
   assign accept    = req_valid && req_ready;

   assign mag_x     = axis_mag(req_x_start, req_x_end);
   assign mag_y     = axis_mag(req_y_start, req_y_end);
   assign dir_new_x = axis_dir(req_x_start, req_x_end);
   assign dir_new_y = axis_dir(req_y_start, req_y_end);
   assign span_new  = (mag_x > mag_y) ? mag_x : mag_y;

   assign span_wide = {1'b0, span_ff};
   assign sum_x     = err_x_ff + {1'b0, abs_dx_ff};
   assign sum_y     = err_y_ff + {1'b0, abs_dy_ff};

   always_comb begin
      cur_x_in       = cur_x_ff;
      cur_y_in       = cur_y_ff;
      err_x_in       = err_x_ff;
      err_y_in       = err_y_ff;
      abs_dx_in      = abs_dx_ff;
      abs_dy_in      = abs_dy_ff;
      span_in        = span_ff;
      dir_x_in       = dir_x_ff;
      dir_y_in       = dir_y_ff;
      pixels_left_in = pixels_left_ff;
      line_color_in  = line_color_ff;
      busy_in        = busy_ff;
      if (accept && (req_command == CMD_START)) begin
         // Load a new line; any running line is dropped
         cur_x_in       = req_x_start;
         cur_y_in       = req_y_start;
         err_x_in       = '0;
         err_y_in       = '0;
         abs_dx_in      = mag_x;
         abs_dy_in      = mag_y;
         span_in        = span_new;
         dir_x_in       = dir_new_x;
         dir_y_in       = dir_new_y;
         pixels_left_in = {1'b0, span_new} + (COORD_BITS+1)'(2);
         line_color_in  = req_color;
         busy_in        = 1'b1;
      end else if (accept && busy_ff) begin
         err_x_in = sum_x;
         err_y_in = sum_y;
         if (sum_x > span_wide) begin
            err_x_in = sum_x - span_wide;
            cur_x_in = axis_move(cur_x_ff, dir_x_ff);
         end
         if (sum_y > span_wide) begin
            err_y_in = sum_y - span_wide;
            cur_y_in = axis_move(cur_y_ff, dir_y_ff);
         end
         if (pixels_left_ff != '0) begin
            pixels_left_in = pixels_left_ff - (COORD_BITS+1)'(1);
         end
         busy_in = (pixels_left_in != '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff        <= 1'b0;
         pixels_left_ff <= '0;
      end else begin
         busy_ff        <= busy_in;
         pixels_left_ff <= pixels_left_in;
      end
      cur_x_ff      <= cur_x_in;
      cur_y_ff      <= cur_y_in;
      err_x_ff      <= err_x_in;
      err_y_ff      <= err_y_in;
      abs_dx_ff     <= abs_dx_in;
      abs_dy_ff     <= abs_dy_in;
      span_ff       <= span_in;
      dir_x_ff      <= dir_x_in;
      dir_y_ff      <= dir_y_in;
      line_color_ff <= line_color_in;
   end

   assign row_sum         = SUM_BITS'(cur_y_ff) + SUM_BITS'(row_offset);
   assign res_valid       = accept && (req_command == CMD_STEP) && busy_ff;
   assign res_pixel_x     = cur_x_ff;
   assign res_pixel_y     = row_sum[COORD_BITS:0];
   assign res_pixel_color = line_color_ff;
   assign res_last        = (pixels_left_ff == (COORD_BITS+1)'(1));

   a_busy_count: assert property (@(posedge clock) disable iff (reset)
      busy_ff == (pixels_left_ff != '0))
      else $error("busy flag disagrees with pixel count");

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (res_valid && res_last) |=> !busy_ff)
      else $error("line still busy after its last pixel");

   a_err_bound: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> ((err_x_ff <= span_wide) && (err_y_ff <= span_wide)))
      else $error("error accumulator above span");

endmodule

// ----- hw/rtl/lpg_skid.sv -----
// ----------------------------------------------------------------------------
// lpg_skid
// Two-entry output register that parts the result stream from the core.
// ----------------------------------------------------------------------------
module lpg_skid #(
   parameter int DATA_BITS = 38
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  logic [DATA_BITS-1:0] in_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic [DATA_BITS-1:0] out_data
);

   logic                 main_valid_ff, main_valid_in;
   logic                 skid_valid_ff, skid_valid_in;
   logic [DATA_BITS-1:0] main_data_ff, main_data_in;
   logic [DATA_BITS-1:0] skid_data_ff, skid_data_in;
   logic                 take;

   assign in_ready = !skid_valid_ff;
   assign take     = main_valid_ff && out_ready;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_data_in  = main_data_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (take) begin
            main_data_in  = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (in_valid) begin
         if (!main_valid_ff || take) begin
            main_data_in  = in_data;
            main_valid_in = 1'b1;
         end else begin
            skid_data_in  = in_data;
            skid_valid_in = 1'b1;
         end
      end else if (take) begin
         main_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_data_ff <= main_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign out_valid = main_valid_ff;
   assign out_data  = main_data_ff;

   a_skid_order: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff)
      else $error("skid entry held without a head entry");

   a_skid_hold: assert property (@(posedge clock) disable iff (reset)
      (main_valid_ff && !out_ready) |=> (main_valid_ff && $stable(main_data_ff)))
      else $error("stalled result changed");

endmodule

// ----- hw/rtl/line_pixel_generator_top.sv -----
// ----------------------------------------------------------------------------
// line_pixel_generator_top
// Line rasteriser: start beats load a line, step beats return its pixels.
// ----------------------------------------------------------------------------
// Usage:
//   req_* is the command stream. req_tuser selects the command: start loads
//   both endpoints and the colour from req_tdata and returns nothing; step
//   returns the next pixel of the running line on rsp_*. A step while no line
//   is running is taken and dropped. A line gives span+2 pixels, span being
//   the larger of the two axis deltas; rsp_tlast marks the final one.
//   csr_* is an APB-style port with one register, row_offset at byte address
//   0, added to every emitted row.
// Timing:
//   One beat per clock on req_*, sustained while rsp_tready is high: the step is
//   a single pass of adds and compares on the line state registers. A pixel is
//   registered in the two-entry output register before it appears on rsp_*.
// Stall:
//   When rsp_tready is low the result is held; one more step is absorbed by
//   the skid entry, then req_tready drops until the receiver drains.
// Reset:
//   Synchronous; the block comes up idle with row_offset at 20.
// ----------------------------------------------------------------------------
module line_pixel_generator_top import lpg_pkg::*; #(
   parameter int COORD_BITS = 10
) (
   input  logic                     clock,
   input  logic                     reset,
   // Command stream
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // tdata, lowest bit up: x_start, y_start, x_end, y_end, color, zero fill
   input  logic [((4*COORD_BITS + COLOR_BITS + 7) / 8) * 8 - 1:0] req_tdata,
   // tuser: command
   input  logic [0:0]               req_tuser,
   // Pixel stream
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // tdata, lowest bit up: pixel_x, pixel_y, pixel_color, zero fill
   output logic [((2*COORD_BITS + 1 + COLOR_BITS + 7) / 8) * 8 - 1:0] rsp_tdata,
   output logic                     rsp_tlast,
   // Register port
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready
);

   localparam int IN_FIELD_BITS  = 4*COORD_BITS + COLOR_BITS;
   localparam int OUT_FIELD_BITS = 2*COORD_BITS + 1 + COLOR_BITS;
   localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;
   localparam int SKID_BITS      = OUT_FIELD_BITS + 1;

   logic [ROW_OFFSET_BITS-1:0] row_offset;
   logic                       res_valid, res_ready, res_last;
   logic [COORD_BITS-1:0]      res_pixel_x;
   logic [COORD_BITS:0]        res_pixel_y;
   logic [COLOR_BITS-1:0]      res_pixel_color;
   logic [SKID_BITS-1:0]       skid_in_data, skid_out_data;

   lpg_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .row_offset  (row_offset)
   );

   // Unpack the command fields; the zero fill above them is not looked at
   lpg_core #(.COORD_BITS(COORD_BITS)) u_core (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_tvalid),
      .req_ready       (req_tready),
      .req_command     (req_tuser[0]),
      .req_x_start     (req_tdata[COORD_BITS-1:0]),
      .req_y_start     (req_tdata[2*COORD_BITS-1:COORD_BITS]),
      .req_x_end       (req_tdata[3*COORD_BITS-1:2*COORD_BITS]),
      .req_y_end       (req_tdata[4*COORD_BITS-1:3*COORD_BITS]),
      .req_color       (req_tdata[IN_FIELD_BITS-1:4*COORD_BITS]),
      .row_offset      (row_offset),
      .res_valid       (res_valid),
      .res_ready       (res_ready),
      .res_pixel_x     (res_pixel_x),
      .res_pixel_y     (res_pixel_y),
      .res_pixel_color (res_pixel_color),
      .res_last        (res_last)
   );

   // Carry the last flag above the packed fields through the output register
   assign skid_in_data = {res_last, res_pixel_color, res_pixel_y, res_pixel_x};

   lpg_skid #(.DATA_BITS(SKID_BITS)) u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (res_valid),
      .in_ready  (res_ready),
      .in_data   (skid_in_data),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (skid_out_data)
   );

   assign rsp_tdata = OUT_DATA_BITS'(skid_out_data[OUT_FIELD_BITS-1:0]);
   assign rsp_tlast = skid_out_data[SKID_BITS-1];

endmodule

// ----- verif/tb_line_pixel_generator_top.sv -----
// ----------------------------------------------------------------------------
// tb_line_pixel_generator_top
// Self-checking bench for the line rasteriser: a table of directed command
// beats, then random lines under random idling on both streams, checked
// against a bench-side rasteriser, with the row offset changed between phases.
// ----------------------------------------------------------------------------
module tb_line_pixel_generator_top import lpg_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int COORD_BITS     = 10;
   localparam int IN_BITS        = ((4 * COORD_BITS + COLOR_BITS + 7) / 8) * 8;
   localparam int OUT_BITS       = ((2 * COORD_BITS + 1 + COLOR_BITS + 7) / 8) * 8;
   localparam int PIX_Y_LSB      = COORD_BITS;
   localparam int PIX_COLOR_LSB  = 2 * COORD_BITS + 1;
   localparam int COORD_MAX      = (1 << COORD_BITS) - 1;
   localparam int SETTLE_CYCLES  = 4;     // step beat to pixel, plus skid entry
   localparam int HOLD_CYCLES    = 300;   // long receiver hold-off
   localparam int WATCHDOG_LIMIT = 4000;  // quiet cycles before giving up
   localparam int IDLE_PERCENT   = 19;
   localparam int PHASE_ITEMS    = 80;
   localparam int NUM_PHASES     = 5;

   localparam logic [CSR_ADDR_BITS-1:0] ROW_OFFSET_ADDR = CSR_ADDR_BITS'(4 * REG_ROW_OFFSET);
   localparam logic [CSR_ADDR_BITS-1:0] UNUSED_ADDR     = ROW_OFFSET_ADDR + CSR_ADDR_BITS'(4);

   typedef logic [COORD_BITS-1:0] coord_type;

   typedef struct packed {
      coord_type              x;
      logic [COORD_BITS:0]    y;
      logic [COLOR_BITS-1:0]  color;
      logic                   last;
   } pixel_beat_type;

   // How a directed row is checked: nothing, a typed pixel, or the rasteriser
   typedef enum logic [1:0] {
      EXP_NONE  = 2'd0,
      EXP_PIXEL = 2'd1,
      EXP_MODEL = 2'd2
   } exp_kind_type;

   typedef struct packed {
      logic                  cmd;
      coord_type             xs;
      coord_type             ys;
      coord_type             xe;
      coord_type             ye;
      logic [COLOR_BITS-1:0] color;
      exp_kind_type          kind;
      pixel_beat_type        pix;
   } directed_row_type;

   typedef struct {
      coord_type             cur_x;
      coord_type             cur_y;
      logic [COORD_BITS:0]   err_x;
      logic [COORD_BITS:0]   err_y;
      coord_type             abs_dx;
      coord_type             abs_dy;
      coord_type             span;
      dir_type               dir_x;
      dir_type               dir_y;
      logic [COORD_BITS:0]   pixels_left;
      logic [COLOR_BITS-1:0] line_color;
      bit                    busy;
   } raster_state_type;

   localparam pixel_beat_type NO_PIX = '0;

   logic                     clock;
   logic                     reset;
   logic                     req_tvalid;
   logic                     req_tready;
   // tdata, lowest bit up: x_start, y_start, x_end, y_end, color
   logic [IN_BITS-1:0]       req_tdata;
   // tuser: command
   logic [0:0]               req_tuser;
   logic                     rsp_tvalid;
   logic                     rsp_tready;
   // tdata, lowest bit up: pixel_x, pixel_y, pixel_color, zero fill
   logic [OUT_BITS-1:0]      rsp_tdata;
   logic                     rsp_tlast;
   logic                     csr_psel;
   logic                     csr_penable;
   logic                     csr_pwrite;
   logic [CSR_ADDR_BITS-1:0] csr_paddr;
   logic [CSR_DATA_BITS-1:0] csr_pwdata;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   raster_state_type             raster;
   logic [ROW_OFFSET_BITS-1:0]   row_offset;
   pixel_beat_type               expected_pixels[$];
   int                           error_count;
   int                           items_sent;
   bit                           no_idle;
   bit                           hold_request;

   // Directed beats. Typed pixels assume the reset row offset of 20.
   directed_row_type directed_rows [22] = '{
      // step straight out of reset: dropped
      '{CMD_STEP,  10'd0,    10'd0,    10'd0,    10'd0,    16'h0000, EXP_NONE,  NO_PIX},
      // equal endpoints: two pixels on the same spot
      '{CMD_START, 10'd5,    10'd7,    10'd5,    10'd7,    16'hFFFF, EXP_NONE,  NO_PIX},
      '{CMD_STEP,  10'h3FF,  10'h3FF,  10'h3FF,  10'h3FF,  16'hFFFF, EXP_PIXEL,
        '{10'd5, 11'd27, 16'hFFFF, 1'b0}},
      '{CMD_STEP,  10'd0,    10'd0,    10'd0,    10'd0,    16'h0000, EXP_PIXEL,
        '{10'd5, 11'd27, 16'hFFFF, 1'b1}},
      // line finished: dropped
      '{CMD_STEP,  10'h3FF,  10'h3FF,  10'h3FF,  10'h3FF,  16'hFFFF, EXP_NONE,  NO_PIX},
      // full diagonal, corner to corner
      '{CMD_START, 10'd0,    10'd0,    10'd1023, 10'd1023, 16'h0000, EXP_NONE,  NO_PIX},
      '{CMD_STEP,  10'd0,    10'd0,    10'd0,    10'd0,    16'h0000, EXP_MODEL, NO_PIX},
      '{CMD_STEP,  10'd0,    10'd0,    10'd0,    10'd0,    16'h0000, EXP_MODEL, NO_PIX},
      '{CMD_STEP,  10'd0,    10'd0,    10'd0,    10'd0,    16'h0000, EXP_MODEL, NO_PIX},
      // start while busy: abandon the diagonal, run the anti-diagonal
      '{CMD_START, 10'd1023, 10'd0,    10'd0,    10'd1023, 16'hA5A5, EXP_NONE,  NO_PIX},
      '{CMD_STEP,  10'd0,    10'd0,    10'd0,    10'd0,    16'h0000, EXP_PIXEL,
        '{10'd1023, 11'd20, 16'hA5A5, 1'b0}},
      '{CMD_STEP,  10'h3FF,  10'h3FF,  10'h3FF,  10'h3FF,  16'hFFFF, EXP_MODEL, NO_PIX},
      '{CMD_STEP,  10'd0,    10'd0,    10'd0,    10'd0,    16'h0000, EXP_MODEL, NO_PIX},
      // short horizontal line, right to left, at the far corner, run to its end
      '{CMD_START, 10'd1023, 10'd1023, 10'd1020, 10'd1023, 16'h5A5A, EXP_NONE,  NO_PIX},
      '{CMD_STEP,  10'd0,    10'd0,    10'd0,    10'd0,    16'h0000, EXP_MODEL, NO_PIX},
      '{CMD_STEP,  10'd0,    10'd0,    10'd0,    10'd0,    16'h0000, EXP_MODEL, NO_PIX},
      '{CMD_STEP,  10'd0,    10'd0,    10'd0,    10'd0,    16'h0000, EXP_MODEL, NO_PIX},
      '{CMD_STEP,  10'd0,    10'd0,    10'd0,    10'd0,    16'h0000, EXP_MODEL, NO_PIX},
      '{CMD_STEP,  10'd0,    10'd0,    10'd0,    10'd0,    16'h0000, EXP_MODEL, NO_PIX},
      // all ones in every field: a point at the largest row sum for the reset offset
      '{CMD_START, 10'h3FF,  10'h3FF,  10'h3FF,  10'h3FF,  16'hFFFF, EXP_NONE,  NO_PIX},
      '{CMD_STEP,  10'h3FF,  10'h3FF,  10'h3FF,  10'h3FF,  16'hFFFF, EXP_PIXEL,
        '{10'd1023, 11'd1043, 16'hFFFF, 1'b0}},
      '{CMD_STEP,  10'h3FF,  10'h3FF,  10'h3FF,  10'h3FF,  16'hFFFF, EXP_PIXEL,
        '{10'd1023, 11'd1043, 16'hFFFF, 1'b1}}
   };

   line_pixel_generator_top #(
      .COORD_BITS (COORD_BITS)
   ) u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // Absolute delta and direction of one axis
   function automatic void axis_setup(input coord_type a, input coord_type b,
                                      output coord_type mag, output dir_type dir);
      if (b > a) begin
         mag = b - a;
         dir = DIR_INC;
      end else if (b == a) begin
         mag = '0;
         dir = DIR_NONE;
      end else begin
         mag = a - b;
         dir = DIR_DEC;
      end
   endfunction

   // Move one coordinate a single step, wrapping at the coordinate width
   function automatic coord_type axis_move(input coord_type c, input dir_type dir);
      case (dir)
         DIR_INC: return c + coord_type'(1);
         DIR_DEC: return c - coord_type'(1);
         default: return c;
      endcase
   endfunction

   // Apply one command beat to the bench rasteriser; returns 1 with the pixel
   // that the beat should produce
   function automatic bit raster_step(input logic cmd, input logic [IN_BITS-1:0] data,
                                      output pixel_beat_type pix);
      coord_type xs;
      coord_type ys;
      coord_type xe;
      coord_type ye;
      pix = '0;
      xs  = data[0*COORD_BITS +: COORD_BITS];
      ys  = data[1*COORD_BITS +: COORD_BITS];
      xe  = data[2*COORD_BITS +: COORD_BITS];
      ye  = data[3*COORD_BITS +: COORD_BITS];
      if (cmd == CMD_START) begin
         axis_setup(xs, xe, raster.abs_dx, raster.dir_x);
         axis_setup(ys, ye, raster.abs_dy, raster.dir_y);
         raster.span        = (raster.abs_dx > raster.abs_dy) ? raster.abs_dx : raster.abs_dy;
         raster.cur_x       = xs;
         raster.cur_y       = ys;
         raster.err_x       = '0;
         raster.err_y       = '0;
         raster.pixels_left = {1'b0, raster.span} + (COORD_BITS+1)'(2);
         raster.line_color  = data[4*COORD_BITS +: COLOR_BITS];
         raster.busy        = 1'b1;
         return 1'b0;
      end
      if (!raster.busy)
         return 1'b0;
      pix.x     = raster.cur_x;
      pix.y     = {1'b0, raster.cur_y} + {1'b0, row_offset};
      pix.color = raster.line_color;
      pix.last  = (raster.pixels_left == (COORD_BITS+1)'(1));
      raster.err_x = raster.err_x + {1'b0, raster.abs_dx};
      raster.err_y = raster.err_y + {1'b0, raster.abs_dy};
      if (raster.err_x > {1'b0, raster.span}) begin
         raster.err_x = raster.err_x - {1'b0, raster.span};
         raster.cur_x = axis_move(raster.cur_x, raster.dir_x);
      end
      if (raster.err_y > {1'b0, raster.span}) begin
         raster.err_y = raster.err_y - {1'b0, raster.span};
         raster.cur_y = axis_move(raster.cur_y, raster.dir_y);
      end
      if (raster.pixels_left != '0)
         raster.pixels_left = raster.pixels_left - (COORD_BITS+1)'(1);
      if (raster.pixels_left == '0)
         raster.busy = 1'b0;
      return 1'b1;
   endfunction

   // Gap after a beat: idle after about one beat in five unless the no-idle stretch runs
   function automatic int idle_gap();
      if (no_idle || $urandom_range(0, 99) >= IDLE_PERCENT)
         return 0;
      return $urandom_range(1, 5);
   endfunction

   // Pick an endpoint a few pixels from c, clamped to the panel
   function automatic coord_type near_coord(input coord_type c);
      int v;
      v = int'(c) + $urandom_range(0, 16) - 8;
      if (v < 0)
         v = 0;
      if (v > COORD_MAX)
         v = COORD_MAX;
      return coord_type'(v);
   endfunction

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         error_count++;
         $display("%0t: pixel %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endtask

   // Offer one command beat, hold it until taken, then queue what it should give
   task automatic send_beat(input logic cmd, input logic [IN_BITS-1:0] data,
                            input exp_kind_type kind, input pixel_beat_type typed_pix);
      pixel_beat_type pix;
      bit             has_pix;
      int             gap;
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= data;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      has_pix = raster_step(cmd, data, pix);
      case (kind)
         EXP_MODEL: if (has_pix) expected_pixels.push_back(pix);
         EXP_PIXEL: expected_pixels.push_back(typed_pix);
         default: ;
      endcase
      // dropped steps do not count as items
      if (cmd == CMD_START || has_pix)
         items_sent++;
      gap = idle_gap();
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic csr_write(input logic [CSR_ADDR_BITS-1:0] addr,
                            input logic [CSR_DATA_BITS-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready)
         @(posedge clock);
      if (addr == ROW_OFFSET_ADDR)
         row_offset = data[ROW_OFFSET_BITS-1:0];
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Read the row offset back and compare with the bench copy
   task automatic csr_check_row_offset();
      logic [CSR_DATA_BITS-1:0] want;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= ROW_OFFSET_ADDR;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready)
         @(posedge clock);
      want = CSR_DATA_BITS'(row_offset);
      if (csr_prdata !== want) begin
         error_count++;
         $display("%0t: row_offset read mismatch, expected %0d, actual %0d",
                  $time, want, csr_prdata);
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Drop the command stream, wait for every queued pixel, then let the pipe empty
   task automatic settle();
      req_tvalid <= 1'b0;
      while (expected_pixels.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Random lines: mostly short lines run to the end, some cut short by a new
   // start, some followed by stray steps, and now and then a long line across
   // the panel that is abandoned early
   task automatic run_lines(input int target);
      int        stop_at;
      int        span_now;
      int        steps;
      int        pick;
      coord_type xs;
      coord_type ys;
      coord_type xe;
      coord_type ye;
      stop_at = items_sent + target;
      while (items_sent < stop_at) begin
         xs   = coord_type'($urandom_range(0, COORD_MAX));
         ys   = coord_type'($urandom_range(0, COORD_MAX));
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            xe = coord_type'($urandom_range(0, COORD_MAX));
            ye = coord_type'($urandom_range(0, COORD_MAX));
         end else begin
            xe = near_coord(xs);
            ye = near_coord(ys);
         end
         send_beat(CMD_START,
                   IN_BITS'({16'($urandom), ye, xe, ys, xs}), EXP_MODEL, NO_PIX);
         span_now = (xe > xs) ? xe - xs : xs - xe;
         if (((ye > ys) ? ye - ys : ys - ye) > span_now)
            span_now = (ye > ys) ? ye - ys : ys - ye;
         pick = $urandom_range(0, 99);
         if (span_now > 16)
            steps = $urandom_range(1, 24);
         else if (pick < 70)
            steps = span_now + 2;
         else if (pick < 85)
            steps = $urandom_range(0, span_now + 1);
         else
            steps = span_now + 2 + $urandom_range(1, 3);
         // step beats carry random junk in tdata, which the block ignores
         repeat (steps)
            send_beat(CMD_STEP, IN_BITS'({$urandom, $urandom}), EXP_MODEL, NO_PIX);
      end
   endtask

   // Receiver: check each pixel beat, then pick next cycle's tready
   initial begin : pixel_sink
      pixel_beat_type want;
      int             hold_left;
      hold_left  = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            if (expected_pixels.size() == 0) begin
               error_count++;
               $display("%0t: pixel beat with none expected, actual x %0d y %0d",
                        $time, rsp_tdata[COORD_BITS-1:0],
                        rsp_tdata[PIX_Y_LSB +: COORD_BITS+1]);
            end else begin
               want = expected_pixels.pop_front();
               check_field("x", want.x, rsp_tdata[COORD_BITS-1:0]);
               check_field("y", want.y, rsp_tdata[PIX_Y_LSB +: COORD_BITS+1]);
               check_field("color", want.color, rsp_tdata[PIX_COLOR_LSB +: COLOR_BITS]);
               check_field("last", want.last, rsp_tlast);
            end
         end
         // a hold-off request starts the long stall, counted here
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= no_idle || ($urandom_range(0, 99) >= IDLE_PERCENT);
         end
      end
   end

   // Watchdog: give up after too many cycles in which nothing moves
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_psel)
            quiet = 0;
         else
            quiet++;
      end
      $display("tb_line_pixel_generator_top NOT OK");
      $finish;
   end

   initial begin : stimulus
      logic [ROW_OFFSET_BITS-1:0] offset_val;
      directed_row_type           row;
      // bench copy of the block comes up idle with the reset offset
      raster       = '{default: '0, dir_x: DIR_NONE, dir_y: DIR_NONE};
      row_offset   = ROW_OFFSET_RESET;
      error_count  = 0;
      items_sent   = 0;
      no_idle      = 1'b0;
      hold_request = 1'b0;
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      req_tuser   <= CMD_START;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed table, checked at the reset row offset
      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         send_beat(row.cmd, IN_BITS'({row.color, row.ye, row.xe, row.ys, row.xs}),
                   row.kind, row.pix);
      end
      settle();
      csr_check_row_offset();

      // random phases at row offsets zero, all ones, random, random, all ones;
      // phase 2 runs without idling, phase 3 carries the long receiver stall
      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         case (phase)
            0:       offset_val = '0;
            1:       offset_val = '1;
            4:       offset_val = '1;
            default: offset_val = ROW_OFFSET_BITS'($urandom);
         endcase
         csr_write(ROW_OFFSET_ADDR, CSR_DATA_BITS'(offset_val));
         // a write past the last register must leave row_offset alone
         if (phase == 0)
            csr_write(UNUSED_ADDR, CSR_DATA_BITS'($urandom_range(1, COORD_MAX)));
         csr_check_row_offset();
         no_idle = (phase == 2);
         if (phase == 3)
            hold_request = 1'b1;
         run_lines(PHASE_ITEMS);
         settle();
      end
      no_idle = 1'b0;
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (error_count == 0 && expected_pixels.size() == 0) begin
         $display("tb_line_pixel_generator_top OK");
      end else begin
         $display("tb_line_pixel_generator_top NOT OK");
      end
      $finish;
   end

endmodule
